### hdl/ows_pkg.sv
// shared types, codes and crc step function for the 1-wire search rom engine
package ows_pkg;

	localparam int unsigned ADDR_BITS = 64;
	localparam int unsigned POS_W = 7;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned CRC_BITS = 56;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		OP_RESTART  = 2'd0,
		OP_PASS     = 2'd1,
		OP_BIT_PAIR = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_BIT_TAKEN   = 3'd0,
		ST_PASS_START  = 3'd1,
		ST_FINISHED    = 3'd2,
		ST_NO_PRESENCE = 3'd3,
		ST_ABORT       = 3'd4,
		ST_COMPLETE    = 3'd5,
		ST_SEQUENCE    = 3'd6
	} status_t;

	typedef struct packed {
		opcode_t opcode;
		logic    presence;
		logic    id_bit;
		logic    complement_bit;
	} in_item_t;

	typedef struct packed {
		status_t              status;
		logic                 direction_bit;
		logic [ADDR_BITS-1:0] found_address;
		logic                 crc_ok;
		logic [7:0]           found_count;
	} result_t;

	// one bit of the dallas crc-8, lsb first
	function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
		logic [7:0] r;
		r = {1'b0, crc[7:1]};
		if (crc[0] ^ b) begin
			r = r ^ CRC_POLY;
		end
		return r;
	endfunction

endpackage

### hdl/ows_in_reg.sv
// input register: holds one accepted word until the search logic takes it
module ows_in_reg
	import ows_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     in_ready,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### hdl/ows_search.sv
// search state and last-discrepancy decision logic with running crc
module ows_search
	import ows_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     advance,
	output result_t  result
);

	logic [ADDR_BITS-1:0] search_addr_q, search_addr_d;
	logic [POS_W-1:0]     last_conflict_q, last_conflict_d;
	logic [POS_W-1:0]     pass_conflict_q, pass_conflict_d;
	logic [POS_W-1:0]     bit_pos_q, bit_pos_d;
	logic                 in_pass_q, in_pass_d;
	logic                 search_done_q, search_done_d;
	logic [7:0]           good_count_q, good_count_d;
	logic [7:0]           crc_q, crc_d;

	logic [POS_W-1:0]     pos_m1;
	logic [IDX_W-1:0]     idx;
	logic                 old_bit;
	logic                 new_bit;

	assign pos_m1 = bit_pos_q - POS_W'(1);
	assign idx = pos_m1[IDX_W-1:0];
	assign old_bit = search_addr_q[idx];

	always_comb begin
		search_addr_d = search_addr_q;
		last_conflict_d = last_conflict_q;
		pass_conflict_d = pass_conflict_q;
		bit_pos_d = bit_pos_q;
		in_pass_d = in_pass_q;
		search_done_d = search_done_q;
		good_count_d = good_count_q;
		crc_d = crc_q;
		new_bit = 1'b0;
		result.status = ST_SEQUENCE;
		result.direction_bit = 1'b0;
		result.found_address = '0;
		result.crc_ok = 1'b0;

		case (item.opcode)
			OP_RESTART: begin
				search_addr_d = '0;
				last_conflict_d = '0;
				pass_conflict_d = '0;
				bit_pos_d = POS_W'(1);
				in_pass_d = 1'b0;
				search_done_d = 1'b0;
				good_count_d = '0;
				crc_d = '0;
				result.status = ST_BIT_TAKEN;
			end
			OP_PASS: begin
				if (search_done_q) begin
					search_done_d = 1'b0;
					in_pass_d = 1'b0;
					result.status = ST_FINISHED;
				end else if (!item.presence) begin
					last_conflict_d = '0;
					in_pass_d = 1'b0;
					result.status = ST_NO_PRESENCE;
				end else begin
					in_pass_d = 1'b1;
					bit_pos_d = POS_W'(1);
					pass_conflict_d = '0;
					crc_d = '0;
					result.status = ST_PASS_START;
				end
			end
			OP_BIT_PAIR: begin
				if (in_pass_q) begin
					if (item.id_bit && item.complement_bit) begin
						last_conflict_d = '0;
						in_pass_d = 1'b0;
						result.status = ST_ABORT;
					end else begin
						// both zero: devices disagree here
						if (item.id_bit == item.complement_bit) begin
							if (bit_pos_q == last_conflict_q) begin
								new_bit = 1'b1;
							end else if (bit_pos_q > last_conflict_q) begin
								new_bit = 1'b0;
								pass_conflict_d = bit_pos_q;
							end else begin
								new_bit = old_bit;
								if (!old_bit) begin
									pass_conflict_d = bit_pos_q;
								end
							end
						end else begin
							new_bit = item.id_bit;
						end
						search_addr_d[idx] = new_bit;
						result.direction_bit = new_bit;
						if (bit_pos_q <= POS_W'(CRC_BITS)) begin
							crc_d = crc8_bit(crc_q, new_bit);
						end
						if (bit_pos_q >= POS_W'(ADDR_BITS)) begin
							for (int i = 0; i < 8; i++) begin
								result.found_address[8*(7-i) +: 8] = search_addr_d[8*i +: 8];
							end
							result.crc_ok = (crc_q == search_addr_d[ADDR_BITS-1 -: 8]);
							if (result.crc_ok && good_count_q != COUNT_MAX) begin
								good_count_d = good_count_q + 8'd1;
							end
							last_conflict_d = pass_conflict_d;
							search_done_d = (pass_conflict_d == '0);
							in_pass_d = 1'b0;
							bit_pos_d = POS_W'(1);
							result.status = ST_COMPLETE;
						end else begin
							bit_pos_d = bit_pos_q + POS_W'(1);
							result.status = ST_BIT_TAKEN;
						end
					end
				end
			end
			default: begin
				result.status = ST_SEQUENCE;
			end
		endcase

		result.found_count = good_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_addr_q <= '0;
			last_conflict_q <= '0;
			pass_conflict_q <= '0;
			bit_pos_q <= POS_W'(1);
			in_pass_q <= 1'b0;
			search_done_q <= 1'b0;
			good_count_q <= '0;
			crc_q <= '0;
		end else if (advance) begin
			search_addr_q <= search_addr_d;
			last_conflict_q <= last_conflict_d;
			pass_conflict_q <= pass_conflict_d;
			bit_pos_q <= bit_pos_d;
			in_pass_q <= in_pass_d;
			search_done_q <= search_done_d;
			good_count_q <= good_count_d;
			crc_q <= crc_d;
		end
	end

endmodule

### hdl/onewire_rom_search_engine.sv
// top level of the 1-wire search rom engine: input register, search logic, result register
// one word in gives one word out. each word passes an input register, one level of
// decision logic and a result register, which takes the result of the held word once it is
// free or being emptied, and a new word can be taken every cycle while the result side keeps up;
// the output register lets the next word be taken while a finished result still waits. restart
// clears the search and the good-device count. a pass-start word carries the presence result
// and reports search finished once a completed pass left no conflict. each bit-pair word
// returns the direction bit to write back using the last-discrepancy rule; an all-ones pair
// aborts the pass. the crc-8 (x^8+x^5+x^4+1) is built one bit at a time as the first 56 address
// bits are settled, so the 64th bit only needs a byte compare; the finished address comes out
// byte-reversed with the family code in the top byte. bus slot timing is outside this block.
module onewire_rom_search_engine
	import ows_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] presence, [1] id_bit, [2] complement_bit, [7:3] zero
	input  logic [7:0]  s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] direction_bit, [64:1] found_address, [65] crc_ok, [73:66] found_count,
	// [79:74] zero
	output logic [79:0] m_axis_tdata,
	// [2:0] status
	output logic [2:0]  m_axis_tuser
);

	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	result_t  result;
	result_t  result_s2;
	logic     valid_s2;

	// unpack the incoming word
	assign in_item.opcode = opcode_t'(s_axis_tuser);
	assign in_item.presence = s_axis_tdata[0];
	assign in_item.id_bit = s_axis_tdata[1];
	assign in_item.complement_bit = s_axis_tdata[2];

	// the held word moves on when the result register is free or being emptied
	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);

	ows_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_item  (in_item),
		.advance  (advance),
		.in_ready (s_axis_tready),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// search state only changes when its result is captured
	ows_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser = result_s2.status;
	assign m_axis_tdata = {6'd0, result_s2.found_count, result_s2.crc_ok,
		result_s2.found_address, result_s2.direction_bit};

	// input side only stalls while a finished result is held back
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output back-pressure");

	// address and crc flag are only reported with a complete address
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_COMPLETE) |-> (m_axis_tdata[65:1] == '0))
		else $error("address or crc flag outside address complete");

	// a direction bit only comes with a bit taken or address complete
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |->
		(m_axis_tuser == ST_BIT_TAKEN || m_axis_tuser == ST_COMPLETE))
		else $error("direction bit set with wrong status");

endmodule
